@@ rtl/core/mts_pkg.sv @@
// mts_pkg: shared types and constants for the min tracking stack
// operation and status codes, controller states, control/status structs
// no dependencies
`timescale 1ns / 1ps

package mts_pkg;

   localparam int DEPTH_DEFAULT       = 256;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // operation codes carried in the request mode field
   typedef enum logic [1:0] {
      MODE_PUSH  = 2'd0,
      MODE_POP   = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_QUERY = 2'd3
   } mode_type;

   // status codes returned with each response
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FETCH,
      ST_RESP
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load_cmd;
      logic execute;
      logic load_top;
   } ctrl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic need_fetch;
   } dp_status_type;

endpackage

@@ rtl/core/mts_req_if.sv @@
// mts_req_if: request channel of the min tracking stack (valid/ready + payload)
// no dependencies
`timescale 1ns / 1ps

interface mts_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    mode;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

@@ rtl/core/mts_rsp_if.sv @@
// mts_rsp_if: response channel of the min tracking stack (valid/ready + payload)
// no dependencies
`timescale 1ns / 1ps

interface mts_rsp_if #(
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_WIDTH = 9
);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic signed [VALUE_WIDTH-1:0] popped;
   logic signed [VALUE_WIDTH-1:0] top;
   logic signed [VALUE_WIDTH-1:0] minimum;
   logic [COUNT_WIDTH-1:0]        count;

   modport source (output valid, output status, output popped, output top,
                   output minimum, output count, input ready);
   modport sink   (input valid, input status, input popped, input top,
                   input minimum, input count, output ready);
endinterface

@@ rtl/core/mts_ctrl.sv @@
// mts_ctrl: controller state machine of the min tracking stack
// sequences command capture, execution, top refetch and response
// depends on mts_pkg
`timescale 1ns / 1ps

module mts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mts_pkg::ctrl_cmd_type cmd,
   input  mts_pkg::dp_status_type dp_status
);
   import mts_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      req_accept;

   // a new transaction may enter while the previous response leaves
   assign req_ready  = (state_ff == ST_IDLE) || ((state_ff == ST_RESP) && rsp_ready);
   assign req_accept = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = dp_status.need_fetch ? ST_FETCH : ST_RESP;
         end
         ST_FETCH: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (req_accept) state_in = ST_EXEC;
            else if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd.load_cmd = req_accept;
      cmd.execute  = 1'b0;
      cmd.load_top = 1'b0;
      rsp_valid    = 1'b0;
      unique case (state_ff)
         ST_IDLE:  begin end
         ST_EXEC:  begin
            cmd.execute = 1'b1;
         end
         ST_FETCH: begin
            cmd.load_top = 1'b1;
         end
         ST_RESP:  begin
            rsp_valid = 1'b1;
         end
         default:  begin end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/mts_datapath.sv @@
// mts_datapath: entry memory, cached top entry, fill count and result registers
// depends on mts_pkg
`timescale 1ns / 1ps

module mts_datapath #(
   parameter int DEPTH       = mts_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = mts_pkg::VALUE_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mts_pkg::ctrl_cmd_type         cmd,
   output mts_pkg::dp_status_type        dp_status,
   input  logic [1:0]                    req_mode,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic [1:0]                    rsp_status,
   output logic signed [VALUE_WIDTH-1:0] rsp_popped,
   output logic signed [VALUE_WIDTH-1:0] rsp_top,
   output logic signed [VALUE_WIDTH-1:0] rsp_minimum,
   output logic [COUNT_WIDTH-1:0]        rsp_count
);
   import mts_pkg::*;

   localparam int AddrWidth  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EntryWidth = 2 * VALUE_WIDTH;

   // each entry holds {value, running minimum}
   logic [EntryWidth-1:0] mem [DEPTH];

   mode_type                      cmd_mode_ff;
   logic signed [VALUE_WIDTH-1:0] cmd_value_ff;
   logic [COUNT_WIDTH-1:0]        count_ff;
   logic [COUNT_WIDTH-1:0]        count_in;
   logic signed [VALUE_WIDTH-1:0] top_value_ff;
   logic signed [VALUE_WIDTH-1:0] top_min_ff;
   status_type                    status_ff;
   logic signed [VALUE_WIDTH-1:0] popped_ff;
   logic [EntryWidth-1:0]         rd_data_ff;

   logic                          is_empty;
   logic                          is_full;
   logic                          do_push;
   logic signed [VALUE_WIDTH-1:0] push_min;
   logic [AddrWidth-1:0]          wr_addr;
   logic [AddrWidth-1:0]          rd_addr;

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == COUNT_WIDTH'(DEPTH));
   assign do_push  = cmd.execute && (cmd_mode_ff == MODE_PUSH) && !is_full;
   assign wr_addr  = count_ff[AddrWidth-1:0];
   // entry below the current top becomes the new top after a pop
   assign rd_addr  = AddrWidth'(count_ff - COUNT_WIDTH'(2));

   // running minimum of the new entry
   assign push_min = (is_empty || (cmd_value_ff < top_min_ff)) ? cmd_value_ff : top_min_ff;

   // a pop that leaves entries behind has to reload the top from memory
   assign dp_status.need_fetch = (cmd_mode_ff == MODE_POP) && (count_ff > COUNT_WIDTH'(1));

   // command capture
   always_ff @(posedge clock) begin
      if (cmd.load_cmd) begin
         cmd_mode_ff  <= mode_type'(req_mode);
         cmd_value_ff <= req_value;
      end
   end

   // next fill count
   always_comb begin
      count_in = count_ff;
      if (cmd.execute) begin
         case (cmd_mode_ff)
            MODE_PUSH:  if (!is_full) count_in = count_ff + COUNT_WIDTH'(1);
            MODE_POP:   if (!is_empty) count_in = count_ff - COUNT_WIDTH'(1);
            MODE_CLEAR: count_in = '0;
            default:    count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // status and popped value of the transaction
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= STATUS_OK;
         popped_ff <= '0;
         case (cmd_mode_ff)
            MODE_PUSH:  if (is_full) status_ff <= STATUS_FULL;
            MODE_POP: begin
               if (is_empty) status_ff <= STATUS_EMPTY;
               else popped_ff <= top_value_ff;
            end
            MODE_QUERY: if (is_empty) status_ff <= STATUS_EMPTY;
            default:    status_ff <= STATUS_OK;
         endcase
      end
   end

   // cached top entry: set by a push, reloaded from memory after a pop
   always_ff @(posedge clock) begin
      if (do_push) begin
         top_value_ff <= cmd_value_ff;
         top_min_ff   <= push_min;
      end else if (cmd.load_top) begin
         top_value_ff <= rd_data_ff[EntryWidth-1:VALUE_WIDTH];
         top_min_ff   <= rd_data_ff[VALUE_WIDTH-1:0];
      end
   end

   // entry memory write port
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_addr] <= {cmd_value_ff, push_min};
      end
   end

   // entry memory registered read port
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // response fields
   assign rsp_status  = status_ff;
   assign rsp_popped  = popped_ff;
   assign rsp_top     = is_empty ? '0 : top_value_ff;
   assign rsp_minimum = is_empty ? '0 : top_min_ff;
   assign rsp_count   = count_ff;

endmodule

@@ rtl/core/min_tracking_stack.sv @@
// min_tracking_stack: lifo stack of signed values tracking the running minimum
// push, clear, query and pops that empty the stack run through the exec state
// and then respond; a pop that leaves entries also passes through a fetch state
// (top reload through the registered memory read port). a new transaction is
// not accepted until the previous response is taken.
// reset: synchronous, empties the stack; memory contents are not cleared.
`timescale 1ns / 1ps

module min_tracking_stack #(
   parameter int DEPTH       = mts_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = mts_pkg::VALUE_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = $clog2(DEPTH + 1)
) (
   input  logic      clock,
   input  logic      reset,
   mts_req_if.sink   req_chan,
   mts_rsp_if.source rsp_chan
);
   import mts_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // controller
   mts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .dp_status (dp_status)
   );

   // datapath
   mts_datapath #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .dp_status   (dp_status),
      .req_mode    (req_chan.mode),
      .req_value   (req_chan.value),
      .rsp_status  (rsp_chan.status),
      .rsp_popped  (rsp_chan.popped),
      .rsp_top     (rsp_chan.top),
      .rsp_minimum (rsp_chan.minimum),
      .rsp_count   (rsp_chan.count)
   );

endmodule

@@ tb/min_tracking_stack_test.sv @@
// min_tracking_stack_test: self-checking bench for the min tracking stack
// directed table then biased random phases, checked against an in-bench stack model
// depends on mts_pkg, mts_req_if, mts_rsp_if and min_tracking_stack
`timescale 1ns / 1ps

module min_tracking_stack_test;
   import mts_pkg::*;

   localparam int STACK_DEPTH = DEPTH_DEFAULT;
   localparam int VALUE_WIDTH = VALUE_WIDTH_DEFAULT;
   localparam int IDLE_LIMIT  = 2000;
   localparam int SCRIPT_ROWS = 23;
   localparam int PHASES      = 5;

   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] popped;
      logic signed [31:0] top;
      logic signed [31:0] minimum;
      logic [8:0]         count;
   } stack_result_type;

   typedef struct packed {
      mode_type           op;
      logic signed [31:0] operand;
      logic               pinned;
      stack_result_type   want;
   } command_row_type;

   typedef struct packed {
      int push_pct;
      int pop_pct;
      int query_pct;
      int items;
      bit steady;
   } phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mts_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req_bus ();
   mts_rsp_if #(.VALUE_WIDTH(VALUE_WIDTH)) rsp_bus ();

   // pinned expectation travels alongside the request payload
   logic             pin_expect;
   stack_result_type pinned_result;
   bit               steady = 1'b0;

   // stack model state
   logic signed [31:0] model_values [STACK_DEPTH];
   logic signed [31:0] model_mins   [STACK_DEPTH];
   int                 model_fill = 0;

   stack_result_type expected_q [$];
   int               error_count = 0;
   int               mode_tally [4] = '{0, 0, 0, 0};
   int               full_refusals = 0;
   int               empty_errors = 0;
   int               deepest = 0;

   command_row_type script [SCRIPT_ROWS];
   phase_type       phases [PHASES];

   always #2 clock = ~clock;

   min_tracking_stack u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // advance the model by one command and return what the block should report
   function automatic stack_result_type apply_command(mode_type op,
                                                      logic signed [31:0] operand);
      stack_result_type r;
      r = '0;
      r.status = STATUS_OK;
      case (op)
         MODE_PUSH: begin
            if (model_fill >= STACK_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               model_values[model_fill] = operand;
               if (model_fill == 0 || operand < model_mins[model_fill-1]) begin
                  model_mins[model_fill] = operand;
               end else begin
                  model_mins[model_fill] = model_mins[model_fill-1];
               end
               model_fill++;
            end
         end
         MODE_POP: begin
            if (model_fill == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               model_fill--;
               r.popped = model_values[model_fill];
            end
         end
         MODE_CLEAR: model_fill = 0;
         default: begin
            if (model_fill == 0) r.status = STATUS_EMPTY;
         end
      endcase
      if (model_fill > 0) begin
         r.top     = model_values[model_fill-1];
         r.minimum = model_mins[model_fill-1];
      end
      r.count = 9'(model_fill);
      return r;
   endfunction

   function automatic command_row_type pinned_row(mode_type op, logic signed [31:0] operand,
                                                  status_type st, logic signed [31:0] pop,
                                                  logic signed [31:0] tp,
                                                  logic signed [31:0] mn, int cnt);
      command_row_type row;
      row.op      = op;
      row.operand = operand;
      row.pinned  = 1'b1;
      row.want    = '{st, pop, tp, mn, 9'(cnt)};
      return row;
   endfunction

   function automatic command_row_type free_row(mode_type op, logic signed [31:0] operand);
      command_row_type row;
      row = '0;
      row.op      = op;
      row.operand = operand;
      return row;
   endfunction

   // mostly back to back, sometimes a few cycles, rarely a long pause
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // mix of full-range, clustered small (ties) and extreme values
   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return $urandom;
      if (r < 7) return 32'($signed($urandom_range(0, 16)) - 8);
      case ($urandom_range(0, 3))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: return 32'sd0;
         default: return -32'sd1;
      endcase
   endfunction

   function automatic mode_type pick_mode(phase_type ph);
      int r;
      r = $urandom_range(0, 99);
      if (r < ph.push_pct) return MODE_PUSH;
      if (r < ph.push_pct + ph.pop_pct) return MODE_POP;
      if (r < ph.push_pct + ph.pop_pct + ph.query_pct) return MODE_QUERY;
      return MODE_CLEAR;
   endfunction

   // present one command and hold it until the block takes it
   task automatic drive_command(input mode_type op, input logic signed [31:0] operand,
                                input logic pin, input stack_result_type want);
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.mode  <= op;
      req_bus.value <= operand;
      pin_expect    <= pin;
      pinned_result <= want;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // sender pauses until every outstanding response has come back
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   // response side: random back-pressure, no new stalls begin while steady
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 25) stall_left = pick_gap();
         end
      end
   end

   // scoreboard: check responses, predict accepted requests, watchdog
   always @(posedge clock) begin : scoreboard
      stack_result_type seen;
      stack_result_type want;
      stack_result_type predicted;
      int               idle_cycles;
      bit               moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            seen = '{status_type'(rsp_bus.status), rsp_bus.popped, rsp_bus.top,
                     rsp_bus.minimum, rsp_bus.count};
            if (seen.status == STATUS_FULL) full_refusals++;
            if (seen.status == STATUS_EMPTY) empty_errors++;
            if (int'(seen.count) > deepest) deepest = int'(seen.count);
            if (expected_q.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: response with nothing outstanding: status %0d count %0d",
                           $realtime, seen.status, seen.count);
            end else begin
               want = expected_q.pop_front();
               if (seen.status !== want.status || seen.popped !== want.popped ||
                   seen.top !== want.top || seen.minimum !== want.minimum ||
                   seen.count !== want.count) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"%0t: mismatch exp status %0d popped %0d top %0d min %0d ",
                               "count %0d, got status %0d popped %0d top %0d min %0d count %0d"},
                              $realtime, want.status, want.popped, want.top, want.minimum,
                              want.count, seen.status, seen.popped, seen.top, seen.minimum,
                              seen.count);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            moved = 1'b1;
            mode_tally[req_bus.mode]++;
            predicted = apply_command(mode_type'(req_bus.mode), req_bus.value);
            expected_q.push_back(pin_expect ? pinned_result : predicted);
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end else begin
         idle_cycles = 0;
      end
   end

   initial begin
      phase_type ph;
      req_bus.valid = 1'b0;
      req_bus.mode  = MODE_QUERY;
      req_bus.value = '0;
      pin_expect    = 1'b0;
      pinned_result = '0;

      // directed commands: empty-stack errors, extremes, min tracking, clear
      script[0]  = pinned_row(MODE_QUERY, 32'sd0, STATUS_EMPTY, 0, 0, 0, 0);
      script[1]  = pinned_row(MODE_POP, -32'sd1, STATUS_EMPTY, 0, 0, 0, 0);
      script[2]  = pinned_row(MODE_CLEAR, VAL_MAX, STATUS_OK, 0, 0, 0, 0);
      script[3]  = pinned_row(MODE_PUSH, VAL_MAX, STATUS_OK, 0, VAL_MAX, VAL_MAX, 1);
      script[4]  = pinned_row(MODE_PUSH, VAL_MIN, STATUS_OK, 0, VAL_MIN, VAL_MIN, 2);
      script[5]  = pinned_row(MODE_PUSH, 32'sd0, STATUS_OK, 0, 0, VAL_MIN, 3);
      script[6]  = pinned_row(MODE_QUERY, 32'sd12345, STATUS_OK, 0, 0, VAL_MIN, 3);
      script[7]  = pinned_row(MODE_POP, -32'sd7, STATUS_OK, 0, VAL_MIN, VAL_MIN, 2);
      script[8]  = pinned_row(MODE_POP, 32'sd0, STATUS_OK, VAL_MIN, VAL_MAX, VAL_MAX, 1);
      script[9]  = pinned_row(MODE_POP, 32'sd0, STATUS_OK, VAL_MAX, 0, 0, 0);
      script[10] = free_row(MODE_PUSH, -32'sd100);
      script[11] = free_row(MODE_PUSH, 32'sd200);
      script[12] = free_row(MODE_PUSH, -32'sd300);
      script[13] = free_row(MODE_PUSH, -32'sd300);
      script[14] = free_row(MODE_PUSH, -32'sd1);
      script[15] = free_row(MODE_PUSH, 32'sd1);
      script[16] = free_row(MODE_POP, VAL_MIN);
      script[17] = free_row(MODE_POP, 32'sd0);
      script[18] = free_row(MODE_POP, 32'sd0);
      script[19] = free_row(MODE_QUERY, VAL_MIN);
      script[20] = pinned_row(MODE_CLEAR, 32'sd99, STATUS_OK, 0, 0, 0, 0);
      script[21] = pinned_row(MODE_QUERY, 32'sd0, STATUS_EMPTY, 0, 0, 0, 0);
      script[22] = free_row(MODE_PUSH, -32'sd1);

      // random phases: mixed, fill past full, churn near full, drain past empty, steady
      phases[0] = '{50, 35, 12, 300, 1'b0};
      phases[1] = '{90, 5, 5, 450, 1'b0};
      phases[2] = '{55, 40, 5, 200, 1'b0};
      phases[3] = '{15, 75, 8, 400, 1'b0};
      phases[4] = '{50, 40, 8, 300, 1'b1};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         drive_command(script[i].op, script[i].operand, script[i].pinned, script[i].want);
         hold_off(pick_gap());
      end

      foreach (phases[p]) begin
         wait_drained();
         ph = phases[p];
         steady = ph.steady;
         repeat (ph.items) begin
            drive_command(pick_mode(ph), pick_value(), 1'b0, '0);
            if (!steady) hold_off(pick_gap());
         end
      end

      // let everything outstanding come back, then a short settle
      steady = 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (expected_q.size() != 0) begin
         error_count += expected_q.size();
         $display("%0d responses never arrived", expected_q.size());
      end

      $display("ran %0d push, %0d pop, %0d clear, %0d query transactions",
               mode_tally[MODE_PUSH], mode_tally[MODE_POP], mode_tally[MODE_CLEAR],
               mode_tally[MODE_QUERY]);
      $display("full refusals %0d, empty errors %0d, deepest fill %0d, mismatches %0d",
               full_refusals, empty_errors, deepest, error_count);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/mts_pkg.sv
rtl/core/mts_req_if.sv
rtl/core/mts_rsp_if.sv
rtl/core/mts_ctrl.sv
rtl/core/mts_datapath.sv
rtl/core/min_tracking_stack.sv
tb/min_tracking_stack_test.sv
